>>> sv/afc_pkg.sv
package afc_pkg;

  localparam int COUNT_BITS_DEF = 17;
  localparam int CELL_BYTES = 48;
  localparam int TRAILER_BYTES = 8;
  localparam int TOTAL_BITS = 17;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_LENGTH    = 3'd2;
  localparam logic [2:0] ERR_CELL_SIZE = 3'd3;
  localparam logic [2:0] ERR_CRC       = 3'd4;

  typedef struct packed {
    logic                  frame_ok;
    logic [2:0]            error_code;
    logic [15:0]           payload_length;
    logic [TOTAL_BITS-1:0] total_length;
    logic [31:0]           computed_crc;
    logic [31:0]           received_crc;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } core_out_t;

endpackage

>>> sv/afc_pdu_if.sv
interface afc_pdu_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/afc_result_if.sv
interface afc_result_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [2:0]  error_code;
  logic [15:0] payload_length;
  logic [16:0] total_length;
  logic [31:0] computed_crc;
  logic [31:0] received_crc;

  modport source (
    output valid, output frame_ok, output error_code, output payload_length,
    output total_length, output computed_crc, output received_crc, input ready
  );
  modport sink (
    input valid, input frame_ok, input error_code, input payload_length,
    input total_length, input computed_crc, input received_crc, output ready
  );
endinterface

>>> sv/aal5_frame_checker_unit.sv
// AAL5 CPCS-PDU checker.
// pdu channel (sink): one byte per item, data_byte in transmission order,
// last_byte set on the final byte of the PDU.
// res channel (source): one item per PDU, given for its final byte, with
// frame_ok, the first failing check in error_code, the trailer length field,
// the saturating byte count, the CRC-32 over all but the last four bytes and
// the big-endian trailer CRC.
// throughput: one byte per cycle while pdu.ready is high; the CRC-32 byte update
// feeds the running CRC register back to itself.
// latency: the result is valid in the cycle after the final byte is taken
// when the output register is free or emptied in that cycle.
// the output holds two results (output register plus skid entry); bytes keep
// flowing while one result waits, and pdu.ready drops only while both are
// full, until the receiver takes one.
// reset: synchronous, active high; clears the running CRC, the byte count
// and both result entries, so the next byte starts a new PDU.
module aal5_frame_checker_unit
  import afc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic clk,
  input logic rst,
  afc_pdu_if.sink pdu,
  afc_result_if.source res
);

  core_out_t core_result;
  logic      can_accept;
  logic      accept;

  assign pdu.ready = can_accept;
  assign accept = pdu.valid && pdu.ready;

  afc_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .data_byte(pdu.data_byte),
    .last_byte(pdu.last_byte),
    .result(core_result)
  );

  afc_out_buf u_out_buf (
    .clk(clk),
    .rst(rst),
    .push(core_result),
    .can_accept(can_accept),
    .res(res)
  );

  assert property (@(posedge clk) disable iff (rst)
    (accept && pdu.last_byte) |=> res.valid)
    else $error("result missing after final byte");

  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.frame_ok == (res.error_code == ERR_OK)))
    else $error("frame_ok disagrees with error_code");

  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.error_code == ERR_SHORT) |->
      (res.computed_crc == 32'd0 && res.received_crc == 32'd0 &&
       res.payload_length == 16'd0))
    else $error("short pdu result not zeroed");

  assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready && !pdu.ready) |=> res.valid)
    else $error("result dropped while both entries full");

endmodule

>>> sv/afc_core.sv
module afc_core
  import afc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output core_out_t  result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  logic [31:0]           running_crc;
  logic [31:0]           crc_history [3];
  logic [7:0]            tail_bytes [5];
  logic [COUNT_BITS-1:0] byte_count;
  logic [5:0]            cell_pos;

  logic [COUNT_BITS-1:0] byte_count_next;
  logic [5:0]            cell_pos_next;
  logic [COUNT_BITS:0]   need_len;
  logic [15:0]           plen;
  logic [31:0]           rcrc;
  logic [31:0]           ccrc;
  logic                  too_short;
  logic [2:0]            code;

  assign byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  assign cell_pos_next = (cell_pos == 6'(CELL_BYTES - 1)) ? 6'd0 : cell_pos + 6'd1;
  assign too_short = byte_count_next < COUNT_BITS'(TRAILER_BYTES);
  assign plen = too_short ? 16'd0 : {tail_bytes[4], tail_bytes[3]};
  assign rcrc = too_short ? 32'd0 : {tail_bytes[2], tail_bytes[1], tail_bytes[0], data_byte};
  assign ccrc = too_short ? 32'd0 : ~crc_history[2];
  assign need_len = (COUNT_BITS+1)'(plen) + (COUNT_BITS+1)'(TRAILER_BYTES);

  always_comb begin
    priority if (too_short) begin
      code = ERR_SHORT;
    end else if (need_len > {1'b0, byte_count_next}) begin
      code = ERR_LENGTH;
    end else if (byte_count_next == COUNT_MAX || cell_pos_next != 6'd0) begin
      code = ERR_CELL_SIZE;
    end else if (ccrc != rcrc) begin
      code = ERR_CRC;
    end else begin
      code = ERR_OK;
    end
  end

  always_comb begin
    result.valid = accept && last_byte;
    result.data.frame_ok = (code == ERR_OK);
    result.data.error_code = code;
    result.data.payload_length = plen;
    result.data.total_length = (byte_count_next > COUNT_BITS'(TOTAL_MAX)) ?
                               TOTAL_MAX : byte_count_next[TOTAL_BITS-1:0];
    result.data.computed_crc = ccrc;
    result.data.received_crc = rcrc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT;
      byte_count <= '0;
      cell_pos <= '0;
    end else if (accept) begin
      if (last_byte) begin
        running_crc <= CRC_INIT;
        byte_count <= '0;
        cell_pos <= '0;
      end else begin
        running_crc <= crc_byte(running_crc, data_byte);
        byte_count <= byte_count_next;
        cell_pos <= cell_pos_next;
      end
    end
  end

  // history and tail only read once eight bytes of the current pdu are in
  always_ff @(posedge clk) begin
    if (accept) begin
      crc_history[0] <= running_crc;
      crc_history[1] <= crc_history[0];
      crc_history[2] <= crc_history[1];
      tail_bytes[0] <= data_byte;
      for (int i = 1; i < 5; i++) begin
        tail_bytes[i] <= tail_bytes[i-1];
      end
    end
  end

endmodule

>>> sv/afc_out_buf.sv
module afc_out_buf
  import afc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  core_out_t push,
  output logic      can_accept,
  afc_result_if.source res
);

  result_t main_item;
  result_t skid_item;
  logic    main_valid;
  logic    skid_valid;
  logic    pop;

  assign can_accept = !skid_valid;
  assign pop = main_valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push.valid) begin
        main_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_item <= skid_item;
      end else if (push.valid) begin
        main_item <= push.data;
      end
    end else if (push.valid) begin
      if (!main_valid) begin
        main_item <= push.data;
      end else begin
        skid_item <= push.data;
      end
    end
  end

  assign res.valid = main_valid;
  assign res.frame_ok = main_item.frame_ok;
  assign res.error_code = main_item.error_code;
  assign res.payload_length = main_item.payload_length;
  assign res.total_length = main_item.total_length;
  assign res.computed_crc = main_item.computed_crc;
  assign res.received_crc = main_item.received_crc;

endmodule
